[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/csclab_pkg.sv]
// ---------------------------------------------------------------------------
// csclab_pkg
// Types and constants of the strand component labeler.
// ---------------------------------------------------------------------------
package csclab_pkg;

    localparam int MAX_CROSSINGS_DEF = 64;
    localparam int INDEX_W           = 6;
    localparam int VIEW_W            = 2;
    localparam int LABEL_W           = 7;
    localparam int COUNT_W           = 8;
    localparam int NBR_SLOTS         = 4;
    localparam int SLOT_W            = 2;
    // table entry: view parities on top, then four neighbor indices
    localparam int TABLE_W           = NBR_SLOTS * INDEX_W + NBR_SLOTS;

    typedef struct packed {
        logic [INDEX_W-1:0] neighbor_0;
        logic [INDEX_W-1:0] neighbor_1;
        logic [INDEX_W-1:0] neighbor_2;
        logic [INDEX_W-1:0] neighbor_3;
        logic [VIEW_W-1:0]  view_0;
        logic [VIEW_W-1:0]  view_1;
        logic [VIEW_W-1:0]  view_2;
        logic [VIEW_W-1:0]  view_3;
        logic               last_crossing;
    } csclab_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] crossing_index;
        logic [LABEL_W-1:0] over_label;
        logic [LABEL_W-1:0] under_label;
        logic [COUNT_W-1:0] component_count;
        logic               bad_input;
        logic               last_result;
    } csclab_result_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_ROW,
        ST_EDGE_RD,
        ST_EDGE_UPD,
        ST_PASS_END,
        ST_RANK_RD,
        ST_RANK_CHK,
        ST_RANK_FOL,
        ST_OUT_RD,
        ST_OUT_SHOW
    } csclab_state_t;

    typedef enum logic [1:0] {
        RSEL_EDGE,
        RSEL_RANK,
        RSEL_OUT
    } csclab_rsel_t;

    typedef struct packed {
        logic         load;
        logic         init_wr;
        logic         edge_upd;
        logic         pass_end;
        logic         rank_chk;
        logic         rank_fol;
        logic         out_show;
        csclab_rsel_t rsel;
    } csclab_cmd_t;

    typedef struct packed {
        logic item_fire;
        logic item_last;
        logic result_fire;
        logic row_last;
        logic slot_last;
        logic strand_last;
        logic changed;
        logic is_root;
    } csclab_status_t;

endpackage

[src/crossing_strand_component_labeler_top.sv]
// ---------------------------------------------------------------------------
// Crossing strand component labeler - top level
// Load: one record word per cycle. After the last record: label init of each
// strand, then P relaxation passes (a table read per crossing, a label RAM
// read-modify-write per slot per crossing, and a pass-end step), ranking with
// a read, a check and, for a non-root, a follow step per strand, and a read and
// a show step per result word. Async active-low reset empties batch.
// ---------------------------------------------------------------------------
//
// Record words are written into the crossing table while the block is in its
// load phase; item_stall stays low there and high at every other time. The
// word flagged last_crossing closes the batch (a word past capacity is dropped
// and flags bad_input, but its last flag is still honored).
//
// Labeling runs on two copies of the strand label RAM so that both ends of a
// joining edge are read in the same cycle:
//   - init: label every strand with its own number
//   - pass: for each crossing and slot, pull the larger endpoint label down
//     to the smaller; repeat whole passes until one makes no change
//   - rank: walk strands in order; a strand that still labels itself opens a
//     new component number, any other takes the already ranked number of its
//     root, which always lies at a lower strand number
//   - drain: one result word per crossing, held until result_stall drops
// P is the number of passes until no label changes, plus one quiet pass.
//
module crossing_strand_component_labeler_top import csclab_pkg::*; #(
    parameter int MAX_CROSSINGS = MAX_CROSSINGS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  csclab_item_t   item,
    output logic           result_valid,
    input  logic           result_stall,
    output csclab_result_t result
);

    // command and status between sequencer and datapath
    csclab_cmd_t    cmd;
    csclab_status_t status;

    csclab_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    csclab_dp #(
        .MAX_CROSSINGS (MAX_CROSSINGS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[src/csclab_ram.sv]
// ---------------------------------------------------------------------------
// csclab_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module csclab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/csclab_ctrl.sv]
// ---------------------------------------------------------------------------
// csclab_ctrl
// Sequencer: load, label init, relaxation passes, ranking, result drain.
// ---------------------------------------------------------------------------
module csclab_ctrl import csclab_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  csclab_status_t status,
    output csclab_cmd_t    cmd
);

    csclab_state_t state_reg;
    csclab_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (status.item_fire && status.item_last)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (status.strand_last)
                begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                state_next = ST_EDGE_RD;
            end
            ST_EDGE_RD:
            begin
                state_next = ST_EDGE_UPD;
            end
            ST_EDGE_UPD:
            begin
                if (!status.slot_last)
                begin
                    state_next = ST_EDGE_RD;
                end
                else if (status.row_last)
                begin
                    state_next = ST_PASS_END;
                end
                else
                begin
                    state_next = ST_ROW;
                end
            end
            ST_PASS_END:
            begin
                state_next = status.changed ? ST_ROW : ST_RANK_RD;
            end
            ST_RANK_RD:
            begin
                state_next = ST_RANK_CHK;
            end
            ST_RANK_CHK:
            begin
                if (!status.is_root)
                begin
                    state_next = ST_RANK_FOL;
                end
                else if (status.strand_last)
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_RANK_RD;
                end
            end
            ST_RANK_FOL:
            begin
                state_next = status.strand_last ? ST_OUT_RD : ST_RANK_RD;
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_SHOW;
            end
            ST_OUT_SHOW:
            begin
                if (status.result_fire)
                begin
                    state_next = status.row_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.rsel     = RSEL_EDGE;
        unique case (state_reg)
            ST_LOAD:     cmd.load = 1'b1;
            ST_INIT:     cmd.init_wr = 1'b1;
            ST_ROW:      cmd.rsel = RSEL_EDGE;
            ST_EDGE_RD:  cmd.rsel = RSEL_EDGE;
            ST_EDGE_UPD: cmd.edge_upd = 1'b1;
            ST_PASS_END: cmd.pass_end = 1'b1;
            ST_RANK_RD:  cmd.rsel = RSEL_RANK;
            ST_RANK_CHK:
            begin
                cmd.rsel     = RSEL_RANK;
                cmd.rank_chk = 1'b1;
            end
            ST_RANK_FOL:
            begin
                cmd.rsel     = RSEL_RANK;
                cmd.rank_fol = 1'b1;
            end
            ST_OUT_RD:   cmd.rsel = RSEL_OUT;
            ST_OUT_SHOW:
            begin
                cmd.rsel     = RSEL_OUT;
                cmd.out_show = 1'b1;
            end
            default:     cmd.rsel = RSEL_EDGE;
        endcase
    end

endmodule

[src/csclab_dp.sv]
// ---------------------------------------------------------------------------
// csclab_dp
// Crossing table, strand label memories, counters and result word.
// ---------------------------------------------------------------------------
module csclab_dp import csclab_pkg::*; #(
    parameter int MAX_CROSSINGS = MAX_CROSSINGS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  csclab_cmd_t    cmd,
    output csclab_status_t status,
    input  logic           item_valid,
    output logic           item_stall,
    input  csclab_item_t   item,
    output logic           result_valid,
    input  logic           result_stall,
    output csclab_result_t result
);

    localparam int IW = (MAX_CROSSINGS > 1) ? $clog2(MAX_CROSSINGS) : 1;
    localparam int LW = $clog2(2 * MAX_CROSSINGS);
    localparam int CW = $clog2(MAX_CROSSINGS + 1);

    logic [CW-1:0]      cnt_reg;
    logic               err_reg;
    logic [IW-1:0]      row_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [LW-1:0]      strand_reg;
    logic [COUNT_W-1:0] rank_reg;
    logic               changed_reg;

    logic                        item_fire;
    logic                        result_fire;
    logic                        full;
    logic                        tab_we;
    logic [TABLE_W-1:0]          tab_wdata;
    logic [TABLE_W-1:0]          tab_rdata;
    logic [NBR_SLOTS-1:0][INDEX_W-1:0] nbrs;
    logic [NBR_SLOTS-1:0]        pars;
    logic [INDEX_W-1:0]          nb;
    logic                        nb_ok;
    logic [LW-1:0]               addr_a;
    logic [LW-1:0]               addr_b;
    logic [LW-1:0]               raddr_a;
    logic [LW-1:0]               raddr_b;
    logic [LABEL_W-1:0]          rd_a;
    logic [LABEL_W-1:0]          rd_b;
    logic                        lbl_we;
    logic [LW-1:0]               lbl_waddr;
    logic [LABEL_W-1:0]          lbl_wdata;
    logic                        row_last;
    logic                        strand_last;
    logic                        is_root;
    logic [LW-1:0]               strand_adv;

    assign item_stall   = !cmd.load;
    assign item_fire    = item_valid && cmd.load;
    assign result_valid = cmd.out_show;
    assign result_fire  = cmd.out_show && !result_stall;

    assign full     = (cnt_reg == CW'(MAX_CROSSINGS));
    assign row_last = ((COUNT_W'(row_reg) + COUNT_W'(1)) == COUNT_W'(cnt_reg));
    assign strand_last = ((COUNT_W'(strand_reg) + COUNT_W'(1)) ==
                          COUNT_W'({cnt_reg, 1'b0}));
    assign strand_adv  = strand_last ? '0 : strand_reg + LW'(1);

    // crossing table: parities above the four neighbor indices
    assign tab_we    = item_fire && !full;
    assign tab_wdata = {item.view_3[0], item.view_2[0], item.view_1[0], item.view_0[0],
                        item.neighbor_3, item.neighbor_2, item.neighbor_1,
                        item.neighbor_0};

    csclab_ram #(
        .WIDTH (TABLE_W),
        .DEPTH (MAX_CROSSINGS)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (IW'(cnt_reg)),
        .wdata (tab_wdata),
        .raddr (row_reg),
        .rdata (tab_rdata)
    );

    assign nbrs  = tab_rdata[NBR_SLOTS*INDEX_W-1:0];
    assign pars  = tab_rdata[TABLE_W-1:NBR_SLOTS*INDEX_W];
    assign nb    = nbrs[slot_reg];
    assign nb_ok = (COUNT_W'(nb) < COUNT_W'(cnt_reg));

    // strand endpoints of the current edge
    assign addr_a = LW'({row_reg, slot_reg[0]});
    assign addr_b = LW'({nb, pars[slot_reg]});

    always_comb
    begin
        unique case (cmd.rsel)
            RSEL_EDGE:
            begin
                raddr_a = addr_a;
                raddr_b = addr_b;
            end
            RSEL_RANK:
            begin
                raddr_a = strand_reg;
                raddr_b = LW'(rd_a);
            end
            RSEL_OUT:
            begin
                raddr_a = LW'({row_reg, 1'b0});
                raddr_b = LW'({row_reg, 1'b1});
            end
            default:
            begin
                raddr_a = addr_a;
                raddr_b = addr_b;
            end
        endcase
    end

    assign is_root = (rd_a == LABEL_W'(strand_reg));

    always_comb
    begin
        lbl_we    = 1'b0;
        lbl_waddr = strand_reg;
        lbl_wdata = LABEL_W'(strand_reg);
        if (cmd.init_wr)
        begin
            lbl_we = 1'b1;
        end
        else if (cmd.edge_upd && nb_ok)
        begin
            // pull the larger label down to the smaller one
            if (rd_a < rd_b)
            begin
                lbl_we    = 1'b1;
                lbl_waddr = addr_b;
                lbl_wdata = rd_a;
            end
            else if (rd_b < rd_a)
            begin
                lbl_we    = 1'b1;
                lbl_waddr = addr_a;
                lbl_wdata = rd_b;
            end
        end
        else if (cmd.rank_chk && is_root)
        begin
            lbl_we    = 1'b1;
            lbl_wdata = LABEL_W'(rank_reg);
        end
        else if (cmd.rank_fol)
        begin
            lbl_we    = 1'b1;
            lbl_wdata = rd_b;
        end
    end

    // two copies written together give two read ports
    csclab_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (2 * MAX_CROSSINGS)
    ) u_label_a (
        .clk   (clk),
        .we    (lbl_we),
        .waddr (lbl_waddr),
        .wdata (lbl_wdata),
        .raddr (raddr_a),
        .rdata (rd_a)
    );

    csclab_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (2 * MAX_CROSSINGS)
    ) u_label_b (
        .clk   (clk),
        .we    (lbl_we),
        .waddr (lbl_waddr),
        .wdata (lbl_wdata),
        .raddr (raddr_b),
        .rdata (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            err_reg     <= 1'b0;
            row_reg     <= '0;
            slot_reg    <= '0;
            strand_reg  <= '0;
            rank_reg    <= '0;
            changed_reg <= 1'b0;
        end
        else
        begin
            if (item_fire)
            begin
                if (full)
                begin
                    err_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            if (cmd.init_wr)
            begin
                strand_reg  <= strand_adv;
                changed_reg <= 1'b0;
                rank_reg    <= '0;
            end
            if (cmd.edge_upd)
            begin
                if (!nb_ok)
                begin
                    err_reg <= 1'b1;
                end
                else if (rd_a != rd_b)
                begin
                    changed_reg <= 1'b1;
                end
                slot_reg <= slot_reg + SLOT_W'(1);
                if (slot_reg == SLOT_W'(NBR_SLOTS - 1))
                begin
                    row_reg <= row_last ? '0 : row_reg + IW'(1);
                end
            end
            if (cmd.pass_end)
            begin
                changed_reg <= 1'b0;
            end
            if (cmd.rank_chk && is_root)
            begin
                rank_reg   <= rank_reg + COUNT_W'(1);
                strand_reg <= strand_adv;
            end
            if (cmd.rank_fol)
            begin
                strand_reg <= strand_adv;
            end
            if (result_fire)
            begin
                if (row_last)
                begin
                    row_reg <= '0;
                    cnt_reg <= '0;
                    err_reg <= 1'b0;
                end
                else
                begin
                    row_reg <= row_reg + IW'(1);
                end
            end
        end
    end

    assign result.crossing_index  = INDEX_W'(row_reg);
    assign result.over_label      = rd_a;
    assign result.under_label     = rd_b;
    assign result.component_count = rank_reg;
    assign result.bad_input       = err_reg;
    assign result.last_result     = row_last;

    assign status.item_fire   = item_fire;
    assign status.item_last   = item.last_crossing;
    assign status.result_fire = result_fire;
    assign status.row_last    = row_last;
    assign status.slot_last   = (slot_reg == SLOT_W'(NBR_SLOTS - 1));
    assign status.strand_last = strand_last;
    assign status.changed     = changed_reg;
    assign status.is_root     = is_root;

endmodule

[src/csclab_checker.sv]
// ---------------------------------------------------------------------------
// csclab_checker
// Port-level checks of the strand component labeler.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module csclab_checker import csclab_pkg::*; (
    input logic           clk,
    input logic           rst_n,
    input logic           item_valid,
    input logic           item_stall,
    input csclab_item_t   item,
    input logic           result_valid,
    input logic           result_stall,
    input csclab_result_t result
);

    // hold a stalled result word
    `ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result word changed")

    // no record is taken while results drain
    `ASSERT_IMP(a_no_load_in_drain, clk, rst_n, result_valid, item_stall, "record accepted during result drain")

    // closing a batch stops intake for labeling
    `ASSERT_NXT(a_last_stalls, clk, rst_n, item_valid && !item_stall && item.last_crossing, item_stall, "intake open right after last record")

    // labels stay below the component count
    `ASSERT_IMP(a_label_range, clk, rst_n, result_valid, ({1'b0, result.over_label} < result.component_count) && ({1'b0, result.under_label} < result.component_count), "label not below component count")

endmodule

bind crossing_strand_component_labeler_top csclab_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
